/* hw/rtl/lsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, Q30 constants and CORDIC helpers for the lidar spherical to
// Cartesian conversion core.
// ----------------------------------------------------------------------------
package lsc_pkg;

  // CORDIC datapath width (Q30 values with headroom) and Q30 magnitude width
  localparam int CW           = 33;
  localparam int MW           = 31;
  localparam int CORDIC_STEPS = 30;

  localparam longint Q30_ONE         = 64'sd1073741824;
  localparam longint PI_Q30          = 64'sd3373259426;
  localparam longint HALF_PI_Q30     = 64'sd1686629713;
  localparam longint TWO_PI_Q30      = 64'sd6746518852;
  localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          flip;
  } cordic_t;

  // atan(2^-i) in Q30
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] a;
    case (i)
      0:       a = 30'd843314857;
      1:       a = 30'd497837829;
      2:       a = 30'd263043836;
      3:       a = 30'd133525158;
      4:       a = 30'd67021696;
      5:       a = 30'd33543475;
      6:       a = 30'd16775851;
      7:       a = 30'd8388437;
      8:       a = 30'd4194283;
      9:       a = 30'd2097149;
      10:      a = 30'd1048576;
      11:      a = 30'd524288;
      12:      a = 30'd262144;
      13:      a = 30'd131072;
      14:      a = 30'd65536;
      15:      a = 30'd32768;
      16:      a = 30'd16384;
      17:      a = 30'd8192;
      18:      a = 30'd4096;
      19:      a = 30'd2048;
      20:      a = 30'd1024;
      21:      a = 30'd512;
      22:      a = 30'd256;
      23:      a = 30'd128;
      24:      a = 30'd64;
      25:      a = 30'd32;
      26:      a = 30'd16;
      27:      a = 30'd8;
      28:      a = 30'd4;
      29:      a = 30'd2;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  // One rotation-mode step; shifts are arithmetic (floor)
  function automatic cordic_t cordic_step(input cordic_t c, input int unsigned i);
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    cordic_t              r;
    x  = signed'(c.x);
    y  = signed'(c.y);
    z  = signed'(c.z);
    dx = y >>> i;
    dy = x >>> i;
    at = signed'(CW'(atan_q30(i)));
    if (!z[CW-1]) begin
      r.x = x - dx;
      r.y = y + dy;
      r.z = z - at;
    end else begin
      r.x = x + dx;
      r.y = y - dy;
      r.z = z + at;
    end
    r.flip = c.flip;
    return r;
  endfunction

  // Clamp to [-1, 1] in Q30 and return the magnitude
  function automatic logic [MW-1:0] unit_mag(input logic [CW-1:0] v);
    logic signed [CW-1:0] sv;
    logic signed [CW-1:0] one;
    logic [MW-1:0]        m;
    sv  = signed'(v);
    one = signed'(CW'(Q30_ONE));
    if (sv > one || sv < -one) begin
      m = MW'(Q30_ONE);
    end else if (sv < 0) begin
      m = MW'(-sv);
    end else begin
      m = MW'(sv);
    end
    return m;
  endfunction

endpackage

/* hw/rtl/lidar_spherical_to_cartesian_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_spherical_to_cartesian_core
// Converts lidar returns from azimuth, elevation and range to x, y, z.
// ----------------------------------------------------------------------------
// Takes one lidar return per clock while in_tready is high and gives one Cartesian point per clock:
// x = r*cos(el)*sin(az), y = r*cos(el)*cos(az), z = r*sin(el), rounded to
// nearest, with intensity and timestamp carried along unchanged. Both angles
// are reduced modulo 2*pi, folded into [-pi/2, pi/2] and rotated through two
// 30-stage CORDIC pipelines running side by side; four stages of reduction
// ahead and four of clamping and multiplication behind lie between acceptance
// and the output register. Sustained rate is one word per clock while the
// skid entry is empty; the 30 CORDIC stages set the depth. A two-entry output
// skid keeps the input open while one finished word waits, and in_tready
// drops only while the skid entry is occupied.
module lidar_spherical_to_cartesian_core #(
  parameter int RANGE_BITS      = 20,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata, low bit up: azimuth_angle[16], elevation_angle[15],
  // range_value[RANGE_BITS], intensity_in[16], time_us_in[48], zero pad
  input  logic                                               in_tvalid,
  output logic                                               in_tready,
  input  logic [((95 + RANGE_BITS + 7) / 8) * 8 - 1:0]       in_tdata,
  // out_tdata, low bit up: pos_x, pos_y, pos_z [RANGE_BITS+1 each],
  // intensity_out[16], time_us_out[48], zero pad
  output logic                                               out_tvalid,
  input  logic                                               out_tready,
  output logic [((3 * RANGE_BITS + 67 + 7) / 8) * 8 - 1:0]   out_tdata
);
  import lsc_pkg::*;

  localparam int OUT_DW = ((3 * RANGE_BITS + 67 + 7) / 8) * 8;
  localparam int PW     = RANGE_BITS + 1;
  localparam int PAY_W  = RANGE_BITS + 64;
  localparam int SHIFT  = 30 - ANGLE_FRAC_BITS;
  localparam int TW     = 16 + SHIFT;
  localparam int RW     = (TW > 35) ? TW : 35;
  localparam longint NMULT = (64'sd1 <<< (TW - 1)) / TWO_PI_Q30;
  localparam int KW     = (NMULT < 1) ? 1 : $clog2(NMULT + 1);
  localparam int MPW    = RANGE_BITS + MW;

  // stage map
  localparam int S_CORDIC0 = 3;
  localparam int S_POST    = S_CORDIC0 + CORDIC_STEPS + 1;
  localparam int S_FACT    = S_POST + 1;
  localparam int S_PROD    = S_FACT + 1;
  localparam int S_POS     = S_PROD + 1;
  localparam int NST       = S_POS + 1;

  localparam logic signed [33:0] PI_34     = 34'(PI_Q30);
  localparam logic signed [33:0] TWO_PI_34 = 34'(TWO_PI_Q30);
  localparam logic signed [32:0] PI_33     = 33'(PI_Q30);
  localparam logic signed [32:0] HPI_33    = 33'(HALF_PI_Q30);
  localparam logic [61:0]        RND_F     = 62'h2000_0000;
  localparam logic [MPW-1:0]     RND_P     = MPW'(64'h2000_0000);

  logic en;

  logic [NST-1:0]   vld_r, vld_nxt;
  logic [PAY_W-1:0] pay_r [NST];
  logic [PAY_W-1:0] pay_nxt [NST];

  // reduction stages, lane 0 azimuth, lane 1 elevation
  logic              sgn0_r [2];
  logic              sgn0_nxt [2];
  logic [TW-1:0]     mag0_r [2];
  logic [TW-1:0]     mag0_nxt [2];
  logic [KW-1:0]     k0_r [2];
  logic [KW-1:0]     k0_nxt [2];
  logic signed [33:0] tr1_r [2];
  logic signed [33:0] tr1_nxt [2];
  logic signed [32:0] tw2_r [2];
  logic signed [32:0] tw2_nxt [2];

  cordic_t cr0_nxt [2];
  cordic_t cr_r [CORDIC_STEPS+1][2];
  cordic_t cr_nxt [CORDIC_STEPS+1][2];

  logic [MW-1:0] cmag_r [2];
  logic [MW-1:0] cmag_nxt [2];
  logic [MW-1:0] smag_r [2];
  logic [MW-1:0] smag_nxt [2];
  logic          cneg_r [2];
  logic          cneg_nxt [2];
  logic          sneg_r [2];
  logic          sneg_nxt [2];

  logic [MW-1:0] fxm_r, fxm_nxt, fym_r, fym_nxt, fzm_r, fzm_nxt;
  logic          fxn_r, fxn_nxt, fyn_r, fyn_nxt, fzn_r, fzn_nxt;

  logic [RANGE_BITS-1:0] pxm_r, pxm_nxt, pym_r, pym_nxt, pzm_r, pzm_nxt;
  logic                  pxn_r, pxn_nxt, pyn_r, pyn_nxt, pzn_r, pzn_nxt;

  logic [PW-1:0] posx_r, posx_nxt, posy_r, posy_nxt, posz_r, posz_nxt;

  logic              out_vld_r, out_vld_nxt, sk_vld_r, sk_vld_nxt;
  logic [OUT_DW-1:0] out_dat_r, out_dat_nxt, sk_dat_r, sk_dat_nxt;
  logic [OUT_DW-1:0] p_data;

  logic [15:0] ang_in [2];

  assign en        = !sk_vld_r;
  assign in_tready = en;
  assign ang_in[0] = in_tdata[15:0];
  assign ang_in[1] = {in_tdata[30], in_tdata[30:16]};

  // --------------------------------------------------------------------------
  // valid and payload shift line
  // --------------------------------------------------------------------------
  always_comb begin
    vld_nxt    = {vld_r[NST-2:0], in_tvalid};
    pay_nxt[0] = in_tdata[31 +: PAY_W];
    for (int s = 1; s < NST; s++) begin
      pay_nxt[s] = pay_r[s-1];
    end
  end

  // --------------------------------------------------------------------------
  // angle reduction
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [TW-1:0] t;
    logic [RW-1:0]        rem;
    logic signed [33:0]   trv;
    logic signed [33:0]   twv;
    logic signed [32:0]   fz;
    logic                 fl;
    for (int l = 0; l < 2; l++) begin
      // scale to Q30, split into sign, magnitude and whole turns
      t           = signed'({ang_in[l], {SHIFT{1'b0}}});
      sgn0_nxt[l] = t[TW-1];
      mag0_nxt[l] = t[TW-1] ? TW'(-t) : TW'(t);
      k0_nxt[l]   = '0;
      for (int m = 1; m <= NMULT; m++) begin
        if (RW'(mag0_nxt[l]) >= RW'(longint'(m) * TWO_PI_Q30)) begin
          k0_nxt[l] = k0_nxt[l] + KW'(1);
        end
      end

      // truncating remainder, sign restored
      rem        = RW'(mag0_r[l]) - RW'(longint'(k0_r[l]) * TWO_PI_Q30);
      trv        = signed'(rem[33:0]);
      tr1_nxt[l] = sgn0_r[l] ? -trv : trv;

      // wrap into [-pi, pi]
      if (tr1_r[l] > PI_34) begin
        twv = tr1_r[l] - TWO_PI_34;
      end else if (tr1_r[l] < -PI_34) begin
        twv = tr1_r[l] + TWO_PI_34;
      end else begin
        twv = tr1_r[l];
      end
      tw2_nxt[l] = twv[32:0];

      // fold into [-pi/2, pi/2], flag the negation
      if (tw2_r[l] > HPI_33) begin
        fz = tw2_r[l] - PI_33;
        fl = 1'b1;
      end else if (tw2_r[l] < -HPI_33) begin
        fz = tw2_r[l] + PI_33;
        fl = 1'b1;
      end else begin
        fz = tw2_r[l];
        fl = 1'b0;
      end
      cr0_nxt[l].x    = CW'(CORDIC_GAIN_Q30);
      cr0_nxt[l].y    = '0;
      cr0_nxt[l].z    = CW'(fz);
      cr0_nxt[l].flip = fl;
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC pipeline, one step per stage
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      cr_nxt[0][l] = cr0_nxt[l];
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      for (int l = 0; l < 2; l++) begin
        cr_nxt[i+1][l] = cordic_step(cr_r[i][l], i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // clamp, products and sign
  // --------------------------------------------------------------------------
  always_comb begin
    logic [61:0]      pfx;
    logic [61:0]      pfy;
    logic [MPW-1:0]   ppx;
    logic [MPW-1:0]   ppy;
    logic [MPW-1:0]   ppz;
    logic [RANGE_BITS-1:0] rng;
    for (int l = 0; l < 2; l++) begin
      cmag_nxt[l] = unit_mag(cr_r[CORDIC_STEPS][l].x);
      smag_nxt[l] = unit_mag(cr_r[CORDIC_STEPS][l].y);
      cneg_nxt[l] = cr_r[CORDIC_STEPS][l].x[CW-1] ^ cr_r[CORDIC_STEPS][l].flip;
      sneg_nxt[l] = cr_r[CORDIC_STEPS][l].y[CW-1] ^ cr_r[CORDIC_STEPS][l].flip;
    end

    // direction factors: cos el * sin az, cos el * cos az, sin el
    pfx     = cmag_r[1] * smag_r[0] + RND_F;
    pfy     = cmag_r[1] * cmag_r[0] + RND_F;
    fxm_nxt = pfx[60:30];
    fym_nxt = pfy[60:30];
    fxn_nxt = cneg_r[1] ^ sneg_r[0];
    fyn_nxt = cneg_r[1] ^ cneg_r[0];
    fzm_nxt = smag_r[1];
    fzn_nxt = sneg_r[1];

    // scale by range
    rng     = pay_r[S_FACT][RANGE_BITS-1:0];
    ppx     = rng * fxm_r + RND_P;
    ppy     = rng * fym_r + RND_P;
    ppz     = rng * fzm_r + RND_P;
    pxm_nxt = ppx[RANGE_BITS+29:30];
    pym_nxt = ppy[RANGE_BITS+29:30];
    pzm_nxt = ppz[RANGE_BITS+29:30];
    pxn_nxt = fxn_r;
    pyn_nxt = fyn_r;
    pzn_nxt = fzn_r;

    posx_nxt = pxn_r ? -PW'(pxm_r) : PW'(pxm_r);
    posy_nxt = pyn_r ? -PW'(pym_r) : PW'(pym_r);
    posz_nxt = pzn_r ? -PW'(pzm_r) : PW'(pzm_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        pay_r[s] <= pay_nxt[s];
      end
      for (int l = 0; l < 2; l++) begin
        sgn0_r[l] <= sgn0_nxt[l];
        mag0_r[l] <= mag0_nxt[l];
        k0_r[l]   <= k0_nxt[l];
        tr1_r[l]  <= tr1_nxt[l];
        tw2_r[l]  <= tw2_nxt[l];
        cmag_r[l] <= cmag_nxt[l];
        smag_r[l] <= smag_nxt[l];
        cneg_r[l] <= cneg_nxt[l];
        sneg_r[l] <= sneg_nxt[l];
        for (int i = 0; i <= CORDIC_STEPS; i++) begin
          cr_r[i][l] <= cr_nxt[i][l];
        end
      end
      fxm_r  <= fxm_nxt;
      fym_r  <= fym_nxt;
      fzm_r  <= fzm_nxt;
      fxn_r  <= fxn_nxt;
      fyn_r  <= fyn_nxt;
      fzn_r  <= fzn_nxt;
      pxm_r  <= pxm_nxt;
      pym_r  <= pym_nxt;
      pzm_r  <= pzm_nxt;
      pxn_r  <= pxn_nxt;
      pyn_r  <= pyn_nxt;
      pzn_r  <= pzn_nxt;
      posx_r <= posx_nxt;
      posy_r <= posy_nxt;
      posz_r <= posz_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // output register and skid entry
  // --------------------------------------------------------------------------
  assign p_data = OUT_DW'({pay_r[S_POS][PAY_W-1:RANGE_BITS], posz_r, posy_r, posx_r});

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;
    sk_vld_nxt  = sk_vld_r;
    sk_dat_nxt  = sk_dat_r;
    if (!out_vld_r || out_tready) begin
      if (sk_vld_r) begin
        out_vld_nxt = 1'b1;
        out_dat_nxt = sk_dat_r;
        sk_vld_nxt  = 1'b0;
      end else begin
        out_vld_nxt = vld_r[NST-1];
        out_dat_nxt = p_data;
      end
    end else if (en && vld_r[NST-1]) begin
      // hold the pipeline's word while the output is stalled
      sk_vld_nxt = 1'b1;
      sk_dat_nxt = p_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      sk_vld_r  <= sk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dat_r <= out_dat_nxt;
    sk_dat_r  <= sk_dat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule
